// ===== rtl/nnds_pkg.sv =====
// Shared types, widths and codes for the nearest-neighbour downscaler.
package nnds_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int CFG_W    = 13;
   localparam int COLOUR_W = 8;
   localparam int POS_W    = 12;
   localparam int SIZE_W   = 13;

   localparam logic [CFG_W-1:0] SRC_WIDTH_RESET  = 13'd1920;
   localparam logic [CFG_W-1:0] SRC_HEIGHT_RESET = 13'd1080;
   localparam logic [CFG_W-1:0] MAX_EDGE_RESET   = 13'd256;

   localparam logic [COLOUR_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EDGE   = 2'd2;

   typedef struct packed {
      logic [COLOUR_W-1:0] pixel_blue;
      logic [COLOUR_W-1:0] pixel_green;
      logic [COLOUR_W-1:0] pixel_red;
   } req_payload_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] out_blue;
      logic [COLOUR_W-1:0] out_green;
      logic [COLOUR_W-1:0] out_red;
      logic [COLOUR_W-1:0] out_alpha;
      logic [POS_W-1:0]    out_x;
      logic [POS_W-1:0]    out_y;
      logic [SIZE_W-1:0]   out_width;
      logic [SIZE_W-1:0]   out_height;
      logic                frame_last;
   } rsp_payload_type;

endpackage

// ===== rtl/nnds_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module nnds_divider #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] div_ff, div_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         quo_in    = dividend;
         rem_in    = '0;
         div_in    = divisor;
      end else if (active_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(trial - {1'b0, div_ff}) : DEN_W'(trial);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/nnds_setup.sv =====
// Configuration registers and thumbnail geometry sequencer.
module nnds_setup #(
   parameter int MAX_DIM = nnds_pkg::MAX_DIM_DEFAULT,
   localparam int DIM_W  = $clog2(MAX_DIM + 1),
   localparam int CNT_W  = $clog2(MAX_DIM),
   localparam int QW     = DIM_W + 1,
   localparam int RW     = DIM_W + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nnds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nnds_pkg::CFG_W-1:0]        csr_data,
   output logic                              geo_ready,
   output logic [CNT_W-1:0]                  w_last,
   output logic [CNT_W-1:0]                  h_last,
   output logic [CNT_W-1:0]                  tw_last,
   output logic [CNT_W-1:0]                  th_last,
   output logic [DIM_W-1:0]                  thumb_w,
   output logic [DIM_W-1:0]                  thumb_h,
   output logic [DIM_W-1:0]                  q_step,
   output logic [RW-1:0]                     r_step,
   output logic [RW-1:0]                     two_m,
   output logic [QW-1:0]                     q_base,
   output logic [RW-1:0]                     r_base
);
   import nnds_pkg::*;

   localparam int NUM_W = 2 * DIM_W + 2;
   localparam int DEN_W = DIM_W + 1;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_INIT  = 3'd4;
   localparam logic [2:0] ST_RUN   = 3'd5;

   localparam logic [1:0] DIV_STEP   = 2'd0;  // L / M
   localparam logic [1:0] DIV_BASE   = 2'd1;  // L / 2M
   localparam logic [1:0] DIV_WIDTH  = 2'd2;  // (2WM + L) / 2L
   localparam logic [1:0] DIV_HEIGHT = 2'd3;  // (2HM + L) / 2L

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] res;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (v > MAX_DIM) begin
         res = DIM_W'(MAX_DIM);
      end else begin
         res = DIM_W'(v);
      end
      return res;
   endfunction

   logic [2:0]       state_ff, state_in;
   logic [1:0]       sel_ff, sel_in;
   logic [CFG_W-1:0] src_width_ff, src_width_in;
   logic [CFG_W-1:0] src_height_ff, src_height_in;
   logic [CFG_W-1:0] max_edge_ff, max_edge_in;

   logic [DIM_W-1:0] eff_w_ff, eff_h_ff, eff_l_ff, eff_m_ff;
   logic [DIM_W-1:0] cw, ch, cm, cl;
   logic [NUM_W-1:0] num_w_ff, num_h_ff;
   logic [DIM_W-1:0] q_step_ff, thumb_w_ff, thumb_h_ff;
   logic [RW-1:0]    r_step_ff, r_base_ff;
   logic [QW-1:0]    q_base_ff;

   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quo;
   logic [DEN_W-1:0] div_den, div_rem;
   logic [DIM_W-1:0] size_quo;
   logic             cfg_write;

   assign csr_ready = state_ff == ST_RUN;
   assign geo_ready = state_ff == ST_RUN;

   assign cw = clamp_dim(src_width_ff);
   assign ch = clamp_dim(src_height_ff);
   assign cm = clamp_dim(max_edge_ff);
   assign cl = (cw > ch) ? cw : ch;

   always_comb begin
      cfg_write     = 1'b0;
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      max_edge_in   = max_edge_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SRC_WIDTH: begin
               src_width_in = csr_data;
               cfg_write    = 1'b1;
            end
            CSR_SRC_HEIGHT: begin
               src_height_in = csr_data;
               cfg_write     = 1'b1;
            end
            CSR_MAX_EDGE: begin
               max_edge_in = csr_data;
               cfg_write   = 1'b1;
            end
            default: cfg_write = 1'b0;
         endcase
      end
   end

   always_comb begin
      case (sel_ff)
         DIV_STEP: begin
            div_num = NUM_W'(eff_l_ff);
            div_den = DEN_W'(eff_m_ff);
         end
         DIV_BASE: begin
            div_num = NUM_W'(eff_l_ff);
            div_den = {eff_m_ff, 1'b0};
         end
         DIV_WIDTH: begin
            div_num = num_w_ff;
            div_den = {eff_l_ff, 1'b0};
         end
         default: begin
            div_num = num_h_ff;
            div_den = {eff_l_ff, 1'b0};
         end
      endcase
   end

   assign div_start = state_ff == ST_ISSUE;
   // never zero: the size is at least one pixel
   assign size_quo  = (div_quo == '0) ? DIM_W'(1) : DIM_W'(div_quo);

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_LOAD:  state_in = ST_MUL;
         ST_MUL: begin
            state_in = ST_ISSUE;
            sel_in   = DIV_STEP;
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_done) begin
               if (sel_ff == DIV_HEIGHT) begin
                  state_in = ST_INIT;
               end else begin
                  state_in = ST_ISSUE;
                  sel_in   = sel_ff + 2'd1;
               end
            end
         end
         ST_INIT:  state_in = ST_RUN;
         ST_RUN:   state_in = cfg_write ? ST_LOAD : ST_RUN;
         default:  state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         sel_ff        <= DIV_STEP;
         src_width_ff  <= SRC_WIDTH_RESET;
         src_height_ff <= SRC_HEIGHT_RESET;
         max_edge_ff   <= MAX_EDGE_RESET;
      end else begin
         state_ff      <= state_in;
         sel_ff        <= sel_in;
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         max_edge_ff   <= max_edge_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         eff_w_ff <= cw;
         eff_h_ff <= ch;
         eff_l_ff <= cl;
         eff_m_ff <= (cm > cl) ? cl : cm;
      end
      if (state_ff == ST_MUL) begin
         num_w_ff <= NUM_W'({eff_w_ff, 1'b0}) * NUM_W'(eff_m_ff) + NUM_W'(eff_l_ff);
         num_h_ff <= NUM_W'({eff_h_ff, 1'b0}) * NUM_W'(eff_m_ff) + NUM_W'(eff_l_ff);
      end
      if (state_ff == ST_WAIT && div_done) begin
         case (sel_ff)
            DIV_STEP: begin
               q_step_ff <= DIM_W'(div_quo);
               r_step_ff <= {div_rem[DIM_W-1:0], 1'b0};
            end
            DIV_BASE: begin
               q_base_ff <= QW'(div_quo);
               r_base_ff <= RW'(div_rem);
            end
            DIV_WIDTH: thumb_w_ff <= size_quo;
            default:   thumb_h_ff <= size_quo;
         endcase
      end
   end

   nnds_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign w_last  = CNT_W'(eff_w_ff - DIM_W'(1));
   assign h_last  = CNT_W'(eff_h_ff - DIM_W'(1));
   assign tw_last = CNT_W'(thumb_w_ff - DIM_W'(1));
   assign th_last = CNT_W'(thumb_h_ff - DIM_W'(1));
   assign thumb_w = thumb_w_ff;
   assign thumb_h = thumb_h_ff;
   assign q_step  = q_step_ff;
   assign r_step  = r_step_ff;
   assign two_m   = {eff_m_ff, 1'b0};
   assign q_base  = q_base_ff;
   assign r_base  = r_base_ff;

endmodule

// ===== rtl/nearest_neighbor_downscaler_unit.sv =====
// Nearest-neighbour thumbnail downscaler, top level.
//
// Usage notes:
//  - req_* carries source BGR pixels in raster order; rsp_* carries the picked
//    thumbnail pixels (alpha fixed at 255) with their thumbnail x/y, the
//    thumbnail size and frame_last on the final thumbnail pixel.
//  - csr_* writes src_width (0), src_height (1) and max_edge (2). Any write to
//    those indexes recomputes the geometry and restarts the frame.
//  - A picked pixel appears on rsp_valid the cycle after its request is
//    accepted. Requests are taken one per cycle while req_stall is low;
//    pixels that are not picked produce no response.
//  - After reset and after every register write the geometry sequencer runs
//    four divisions on one shared bit-serial divider. req_stall and csr_ready
//    hold off traffic while it runs.
//  - When rsp_stall is high with a response waiting, req_stall is raised in
//    the same cycle; the single output register holds its response unchanged.
//  - Reset is synchronous; the registers return to 1920 x 1080, edge 256.
//  - After the last thumbnail pixel the rest of the frame is absorbed until
//    width*height source pixels have passed, then the next frame starts.
module nearest_neighbor_downscaler_unit #(
   parameter int MAX_DIM = nnds_pkg::MAX_DIM_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  nnds_pkg::req_payload_type      req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output nnds_pkg::rsp_payload_type      rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nnds_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nnds_pkg::CFG_W-1:0]     csr_data
);
   import nnds_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int QW    = DIM_W + 1;
   localparam int RW    = DIM_W + 1;

   // geometry from the sequencer
   logic             geo_ready;
   logic [CNT_W-1:0] w_last, h_last, tw_last, th_last;
   logic [DIM_W-1:0] thumb_w, thumb_h, q_step;
   logic [RW-1:0]    r_step, two_m, r_base;
   logic [QW-1:0]    q_base;

   nnds_setup #(
      .MAX_DIM (MAX_DIM)
   ) u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geo_ready (geo_ready),
      .w_last    (w_last),
      .h_last    (h_last),
      .tw_last   (tw_last),
      .th_last   (th_last),
      .thumb_w   (thumb_w),
      .thumb_h   (thumb_h),
      .q_step    (q_step),
      .r_step    (r_step),
      .two_m     (two_m),
      .q_base    (q_base),
      .r_base    (r_base)
   );

   // frame walk state
   logic [CNT_W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [CNT_W-1:0] thumb_col_ff, thumb_col_in, thumb_row_ff, thumb_row_in;
   logic [CNT_W-1:0] pick_col_ff, pick_col_in, pick_row_ff, pick_row_in;
   // pick = floor(num / 2M) kept as quotient and remainder
   logic [QW-1:0]    col_q_ff, col_q_in, row_q_ff, row_q_in;
   logic [RW-1:0]    col_r_ff, col_r_in, row_r_ff, row_r_in;
   logic             done_ff, done_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic             req_fire, hit, last, frame_end;
   logic [CNT_W-1:0] pick_col_base, pick_row_base;

   // next-pick advance: num += 2L
   logic [RW:0]      col_rs, row_rs;
   logic             col_c, row_c;
   logic [RW-1:0]    col_r_adv, row_r_adv;
   logic [QW-1:0]    col_q_adv, row_q_adv;
   logic [CNT_W-1:0] col_pick_adv, row_pick_adv;

   assign req_stall = !geo_ready || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;

   assign pick_col_base = (q_base > QW'(w_last)) ? w_last : CNT_W'(q_base);
   assign pick_row_base = (q_base > QW'(h_last)) ? h_last : CNT_W'(q_base);

   always_comb begin
      col_rs       = {1'b0, col_r_ff} + {1'b0, r_step};
      col_c        = col_rs >= {1'b0, two_m};
      col_r_adv    = col_c ? RW'(col_rs - {1'b0, two_m}) : RW'(col_rs);
      col_q_adv    = QW'({1'b0, col_q_ff} + (QW+1)'(q_step) + (QW+1)'(col_c));
      col_pick_adv = (col_q_adv > QW'(w_last)) ? w_last : CNT_W'(col_q_adv);

      row_rs       = {1'b0, row_r_ff} + {1'b0, r_step};
      row_c        = row_rs >= {1'b0, two_m};
      row_r_adv    = row_c ? RW'(row_rs - {1'b0, two_m}) : RW'(row_rs);
      row_q_adv    = QW'({1'b0, row_q_ff} + (QW+1)'(q_step) + (QW+1)'(row_c));
      row_pick_adv = (row_q_adv > QW'(h_last)) ? h_last : CNT_W'(row_q_adv);
   end

   assign hit       = !done_ff && (src_row_ff == pick_row_ff) && (src_col_ff == pick_col_ff);
   assign last      = (thumb_col_ff == tw_last) && (thumb_row_ff == th_last);
   assign frame_end = (src_col_ff == w_last) && (src_row_ff == h_last);

   always_comb begin
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      thumb_col_in = thumb_col_ff;
      thumb_row_in = thumb_row_ff;
      pick_col_in  = pick_col_ff;
      pick_row_in  = pick_row_ff;
      col_q_in     = col_q_ff;
      col_r_in     = col_r_ff;
      row_q_in     = row_q_ff;
      row_r_in     = row_r_ff;
      done_in      = done_ff;

      if (!geo_ready || (req_fire && frame_end)) begin
         // start of frame
         src_col_in   = '0;
         src_row_in   = '0;
         thumb_col_in = '0;
         thumb_row_in = '0;
         pick_col_in  = pick_col_base;
         pick_row_in  = pick_row_base;
         col_q_in     = q_base;
         col_r_in     = r_base;
         row_q_in     = q_base;
         row_r_in     = r_base;
         done_in      = 1'b0;
      end else if (req_fire) begin
         if (hit) begin
            if (last) begin
               done_in = 1'b1;
            end else if (thumb_col_ff == tw_last) begin
               thumb_col_in = '0;
               thumb_row_in = thumb_row_ff + 1'b1;
               row_q_in     = row_q_adv;
               row_r_in     = row_r_adv;
               pick_row_in  = row_pick_adv;
               col_q_in     = q_base;
               col_r_in     = r_base;
               pick_col_in  = pick_col_base;
            end else begin
               thumb_col_in = thumb_col_ff + 1'b1;
               col_q_in     = col_q_adv;
               col_r_in     = col_r_adv;
               pick_col_in  = col_pick_adv;
            end
         end
         if (src_col_ff == w_last) begin
            src_col_in = '0;
            src_row_in = src_row_ff + 1'b1;
         end else begin
            src_col_in = src_col_ff + 1'b1;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire && hit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_blue   = req_payload.pixel_blue;
         rsp_data_in.out_green  = req_payload.pixel_green;
         rsp_data_in.out_red    = req_payload.pixel_red;
         rsp_data_in.out_alpha  = ALPHA_OPAQUE;
         rsp_data_in.out_x      = POS_W'(thumb_col_ff);
         rsp_data_in.out_y      = POS_W'(thumb_row_ff);
         rsp_data_in.out_width  = SIZE_W'(thumb_w);
         rsp_data_in.out_height = SIZE_W'(thumb_h);
         rsp_data_in.frame_last = last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         thumb_col_ff <= '0;
         thumb_row_ff <= '0;
         pick_col_ff  <= '0;
         pick_row_ff  <= '0;
         col_q_ff     <= '0;
         col_r_ff     <= '0;
         row_q_ff     <= '0;
         row_r_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         thumb_col_ff <= thumb_col_in;
         thumb_row_ff <= thumb_row_in;
         pick_col_ff  <= pick_col_in;
         pick_row_ff  <= pick_row_in;
         col_q_ff     <= col_q_in;
         col_r_ff     <= col_r_in;
         row_q_ff     <= row_q_in;
         row_r_ff     <= row_r_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // no requests while the geometry is being worked out
   a_setup_blocks: assert property (@(posedge clock) disable iff (reset)
      !geo_ready |-> req_stall)
      else $error("request accepted during geometry setup");

   // a waiting, stalled response must hold off new requests
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !req_fire)
      else $error("request accepted over a stalled response");

   // source position stays inside the frame
   a_src_bounds: assert property (@(posedge clock) disable iff (reset)
      geo_ready |-> (src_col_ff <= w_last) && (src_row_ff <= h_last))
      else $error("source position outside frame");

   // thumbnail position stays inside the thumbnail
   a_thumb_bounds: assert property (@(posedge clock) disable iff (reset)
      geo_ready |-> (thumb_col_ff <= tw_last) && (thumb_row_ff <= th_last))
      else $error("thumbnail position outside thumbnail");

   // the final pixel closes the frame unless the source frame also ends
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && hit && last && !frame_end) |=> done_ff)
      else $error("frame not closed after final thumbnail pixel");

endmodule
